>>> rtl/core/fir_pkg.sv
`default_nettype none

package fir_pkg;

    // filter dimensions
    localparam int MAX_TAPS   = 128;
    localparam int DATA_WIDTH = 16;
    localparam int ADDR_W     = $clog2(MAX_TAPS);
    localparam int TAPS_W     = 8;
    localparam int IDX_W      = 7;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int OUT_WIDTH  = 39;

    // operation codes
    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

>>> rtl/core/fir_filter_direct_form_core.sv
`default_nettype none

// channel   direction  handshake                payload
// in        input      i_in_valid / o_in_stall  i_operation, i_sample, i_coef_index,
//                                               i_coef_value
// out       output     o_out_valid / i_out_stall o_filtered
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (taps_in_use)
//
// a coefficient load gives no result
// a sample is followed by a walk over the n taps in use (n = taps in use), a pipeline
// drain and a result load before the next acceptance; the walk uses one shared multiply-
// accumulate (reading delay entry i-1 and coefficient i, writing entry i back)
// after reset both memories are cleared, one entry per cycle, all 128 entries, with
// o_in_stall high throughout (cfg writes are still taken)
// a finished result waits in the output register while the next item is accepted;
// a new result is held back until the previous one has been taken
module fir_filter_direct_form_core (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire  [0:0]                           i_operation,
    input  wire  signed [fir_pkg::DATA_WIDTH-1:0] i_sample,
    input  wire  [fir_pkg::IDX_W-1:0]            i_coef_index,
    input  wire  signed [fir_pkg::DATA_WIDTH-1:0] i_coef_value,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic signed [fir_pkg::OUT_WIDTH-1:0] o_filtered,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [fir_pkg::TAPS_W-1:0]           i_cfg_data
);

    localparam int AW = fir_pkg::ADDR_W;
    localparam int DW = fir_pkg::DATA_WIDTH;
    localparam int PW = fir_pkg::PROD_W;
    localparam int OW = fir_pkg::OUT_WIDTH;

    fir_pkg::t_state r_state, n_state;

    // memories
    logic [DW-1:0] dl_mem   [fir_pkg::MAX_TAPS];
    logic [DW-1:0] coef_mem [fir_pkg::MAX_TAPS];

    logic [fir_pkg::TAPS_W-1:0] r_taps;
    logic [AW-1:0]              r_clr_idx;
    logic [AW-1:0]              r_idx;
    logic signed [DW-1:0]       r_sample;
    logic signed [DW-1:0]       r_dl_rdata;
    logic signed [DW-1:0]       r_coef_rdata;
    logic                       r_s1_vld;
    logic                       r_s1_first;
    logic [AW-1:0]              r_s1_idx;
    logic                       r_s2_vld;
    logic signed [PW-1:0]       r_prod;
    logic signed [OW-1:0]       r_acc;
    logic                       r_out_valid;
    logic signed [OW-1:0]       r_filtered;

    logic                       in_acc;
    logic                       out_acc;
    logic                       issue;
    logic                       clr_we;
    logic [AW-1:0]              dl_raddr;
    logic [fir_pkg::TAPS_W-1:0] n_taps_used;
    logic [AW-1:0]              start_idx;
    logic                       load_out;
    logic                       dl_we;
    logic [AW-1:0]              dl_waddr;
    logic signed [DW-1:0]       dl_wdata;
    logic signed [DW-1:0]       s1_data;
    logic                       coef_we;
    logic [AW-1:0]              coef_waddr;
    logic [DW-1:0]              coef_wdata;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_out_valid && !i_out_stall;

    // taps in use, clamped to 1..MAX_TAPS
    always_comb begin
        if (r_taps == '0) begin
            n_taps_used = fir_pkg::TAPS_W'(1);
        end else if (32'(r_taps) > fir_pkg::MAX_TAPS) begin
            n_taps_used = fir_pkg::TAPS_W'(fir_pkg::MAX_TAPS);
        end else begin
            n_taps_used = r_taps;
        end
        start_idx = AW'(n_taps_used - fir_pkg::TAPS_W'(1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fir_pkg::ST_CLEAR: begin
                if (32'(r_clr_idx) == fir_pkg::MAX_TAPS - 1) n_state = fir_pkg::ST_IDLE;
            end
            fir_pkg::ST_IDLE: begin
                if (in_acc && i_operation == fir_pkg::OP_FILTER) n_state = fir_pkg::ST_RUN;
            end
            fir_pkg::ST_RUN: begin
                if (r_idx == '0) n_state = fir_pkg::ST_DRAIN;
            end
            fir_pkg::ST_DRAIN: begin
                if (!r_s1_vld && !r_s2_vld) n_state = fir_pkg::ST_FINISH;
            end
            fir_pkg::ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) n_state = fir_pkg::ST_IDLE;
            end
            default: n_state = fir_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        issue      = 1'b0;
        clr_we     = 1'b0;
        load_out   = 1'b0;
        unique case (r_state)
            fir_pkg::ST_CLEAR:  clr_we     = 1'b1;
            fir_pkg::ST_IDLE:   o_in_stall = 1'b0;
            fir_pkg::ST_RUN:    issue      = 1'b1;
            fir_pkg::ST_DRAIN:  issue      = 1'b0;
            fir_pkg::ST_FINISH: load_out   = !r_out_valid || !i_out_stall;
            default:            o_in_stall = 1'b1;
        endcase
    end

    assign o_cfg_ready = 1'b1;

    // read address: entry i-1 moves into entry i
    assign dl_raddr = (r_idx == '0) ? '0 : r_idx - AW'(1);

    // stage 1 operand: the new sample enters entry 0
    assign s1_data = r_s1_first ? r_sample : r_dl_rdata;

    // memory write selection
    always_comb begin
        dl_we      = clr_we || r_s1_vld;
        dl_waddr   = clr_we ? r_clr_idx : r_s1_idx;
        dl_wdata   = clr_we ? '0 : s1_data;
        coef_we    = clr_we
                  || (in_acc && i_operation == fir_pkg::OP_LOAD
                      && 32'(i_coef_index) < fir_pkg::MAX_TAPS);
        coef_waddr = clr_we ? r_clr_idx : AW'(i_coef_index);
        coef_wdata = clr_we ? '0 : i_coef_value;
    end

    // delay line memory
    always_ff @(posedge i_clk) begin
        if (dl_we) dl_mem[dl_waddr] <= dl_wdata;
        r_dl_rdata <= dl_mem[dl_raddr];
    end

    // coefficient memory
    always_ff @(posedge i_clk) begin
        if (coef_we) coef_mem[coef_waddr] <= coef_wdata;
        r_coef_rdata <= coef_mem[r_idx];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fir_pkg::ST_CLEAR;
            r_clr_idx   <= '0;
            r_taps      <= fir_pkg::TAPS_W'(fir_pkg::MAX_TAPS);
            r_idx       <= '0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clr_we) r_clr_idx <= r_clr_idx + AW'(1);
            if (i_cfg_valid && o_cfg_ready) r_taps <= i_cfg_data;
            if (in_acc && i_operation == fir_pkg::OP_FILTER) begin
                r_idx <= start_idx;
            end else if (issue && r_idx != '0) begin
                r_idx <= r_idx - AW'(1);
            end
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath: multiply, then accumulate
    always_ff @(posedge i_clk) begin
        if (in_acc && i_operation == fir_pkg::OP_FILTER) r_sample <= i_sample;
        r_s1_idx   <= r_idx;
        r_s1_first <= (r_idx == '0);
        r_prod     <= s1_data * r_coef_rdata;
        if (in_acc) begin
            r_acc <= '0;
        end else if (r_s2_vld) begin
            r_acc <= r_acc + {{(OW - PW){r_prod[PW-1]}}, r_prod};
        end
        if (load_out) r_filtered <= r_acc;
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;

    // a filter transaction starts the tap walk on the next cycle
    a_filter_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_operation == fir_pkg::OP_FILTER) |=> r_state == fir_pkg::ST_RUN)
        else $error("filter transaction did not start the tap walk");

    // a coefficient load never leaves the idle state
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_operation == fir_pkg::OP_LOAD) |=> r_state == fir_pkg::ST_IDLE)
        else $error("coefficient load left the idle state");

    // a new result only comes from the finish state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == fir_pkg::ST_FINISH)
        else $error("result appeared outside the finish state");

    // the write-back never hits the entry being read
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && r_s1_vld && r_idx != '0) |-> dl_raddr != r_s1_idx)
        else $error("delay line read and write-back on the same entry");

endmodule

`default_nettype wire
